/* sv/crcc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crcc_pkg: shared types, constants and helpers for the CRC engine
// Register indexes, width-mode codes, the configuration bundle, the queue
// entry and the bit-reversal helpers used by the front and back sections.
// ---------------------------------------------------------------------------
package crcc_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_WIDTH_MODE     = 3'd0;
  localparam logic [2:0] REG_POLYNOMIAL     = 3'd1;
  localparam logic [2:0] REG_INITIAL_VALUE  = 3'd2;
  localparam logic [2:0] REG_REFLECT_INPUT  = 3'd3;
  localparam logic [2:0] REG_REFLECT_OUTPUT = 3'd4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Width-mode codes
  localparam logic [7:0] WM_7  = 8'd7;
  localparam logic [7:0] WM_8  = 8'd8;
  localparam logic [7:0] WM_16 = 8'd16;
  localparam logic [7:0] WM_32 = 8'd32;

  // Reset values of the registers
  localparam logic [7:0]  RST_WIDTH_MODE    = 8'd8;
  localparam logic [31:0] RST_POLYNOMIAL    = 32'h0000_0007;
  localparam logic [31:0] RST_INITIAL_VALUE = 32'h0000_0000;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0]  width_mode;
    logic [31:0] polynomial;
    logic [31:0] initial_value;
    logic        reflect_input;
    logic        reflect_output;
  } cfg_t;

  // One queued byte, already reflected if so configured
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } qitem_t;

  // Head of the queue as seen by the back section
  typedef struct packed {
    logic   valid;
    qitem_t item;
  } q_head_t;

  // Back-section status for checks at the top level
  typedef struct packed {
    logic pop;
    logic pop_last;
  } be_stat_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15 - i];
    end
    return r;
  endfunction

endpackage

/* sv/configurable_crc_engine.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// configurable_crc_engine: byte-serial CRC with programmable settings
//
// Channel | Direction | Contents
// --------+-----------+--------------------------------------------------
// in_*    | slave     | tdata[7:0] data_byte, tlast last_byte
// out_*   | master    | tdata[31:0] crc_value (one per message)
// cfg_*   | write     | addr = register index, wdata = value
//
// One byte per clock sustained while no last byte waits; a byte is written
// into the queue, folded by the back section at the head, and a last byte's
// CRC is captured in the output register that drives out_tvalid. Synchronous
// active-low reset; no clearing pass. Bytes keep flowing while a result
// waits on out_tready; only a last byte waits for the output register, and
// the input stalls once the queue has filled behind it.
// ---------------------------------------------------------------------------
module configurable_crc_engine #(
  parameter int QUEUE_DEPTH = crcc_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic                              in_tlast,
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // [31:0] crc_value
  // Configuration writes
  input  logic                              cfg_we,
  input  logic [crcc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [crcc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  crcc_pkg::cfg_t     cfg_r, cfg_nxt;
  crcc_pkg::q_head_t  head;
  crcc_pkg::be_stat_t be_stat;
  logic               pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  // Register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        crcc_pkg::REG_WIDTH_MODE:     cfg_nxt.width_mode     = cfg_wdata[7:0];
        crcc_pkg::REG_POLYNOMIAL:     cfg_nxt.polynomial     = cfg_wdata;
        crcc_pkg::REG_INITIAL_VALUE:  cfg_nxt.initial_value  = cfg_wdata;
        crcc_pkg::REG_REFLECT_INPUT:  cfg_nxt.reflect_input  = cfg_wdata[0];
        crcc_pkg::REG_REFLECT_OUTPUT: cfg_nxt.reflect_output = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_mode     <= crcc_pkg::RST_WIDTH_MODE;
      cfg_r.polynomial     <= crcc_pkg::RST_POLYNOMIAL;
      cfg_r.initial_value  <= crcc_pkg::RST_INITIAL_VALUE;
      cfg_r.reflect_input  <= 1'b0;
      cfg_r.reflect_output <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  crcc_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .head     (head),
    .pop      (pop),
    .count    (q_count)
  );

  crcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .pop       (pop),
    .stat      (be_stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  // Checks
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue fill count exceeds depth");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (q_count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
    else $error("input stalled while queue has room");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(be_stat.pop_last))
    else $error("result appeared without a last byte");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    be_stat.pop |-> head.valid)
    else $error("pop from empty queue");

  a_reset_out: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

/* sv/crcc_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crcc_front: input side and byte queue
// Takes bytes off the input stream, applies input reflection and holds them
// in a small circular queue until the back section pops them.
// ---------------------------------------------------------------------------
module crcc_front #(
  parameter int DEPTH = crcc_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  crcc_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  output crcc_pkg::q_head_t           head,
  input  logic                        pop,
  output logic [$clog2(DEPTH+1)-1:0]  count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  crcc_pkg::qitem_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  crcc_pkg::qitem_t wr_item;

  // Classification: reflect the byte on the way in
  always_comb begin
    wr_item.data_byte = cfg.reflect_input ? crcc_pkg::rev8(in_byte) : in_byte;
    wr_item.last_byte = in_last;
  end

  assign in_ready = (cnt_r != CNT_FULL);
  assign push     = in_valid && in_ready;

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign count      = cnt_r;

endmodule

/* sv/crcc_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crcc_back: CRC fold and result register
// Pops queued bytes, folds each into the running CRC with eight shift/xor
// steps and places the finished, optionally reflected value in the output
// register on the last byte of a message.
// ---------------------------------------------------------------------------
module crcc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crcc_pkg::cfg_t       cfg,
  input  crcc_pkg::q_head_t    head,
  output logic                 pop,
  output crcc_pkg::be_stat_t   stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_data
);

  logic [31:0] crc_r, crc_nxt;
  logic        start_r, start_nxt;
  logic        oval_r, oval_nxt;
  logic [31:0] odata_r, odata_nxt;
  logic [31:0] base;
  logic [31:0] folded;
  logic [31:0] result;
  logic        out_free;

  // Eight shift/xor steps, tested bit and final mask set by the width mode
  function automatic logic [31:0] fold8(input logic [31:0] r, input logic [31:0] top,
                                        input logic [31:0] mask, input logic [31:0] poly);
    logic [31:0] v;
    v = r;
    for (int k = 0; k < 8; k++) begin
      v = ((v & top) != '0) ? ((v << 1) ^ poly) : (v << 1);
    end
    return v & mask;
  endfunction

  assign base = start_r ? cfg.initial_value : crc_r;

  always_comb begin
    case (cfg.width_mode)
      crcc_pkg::WM_7:
        folded = fold8(base ^ {24'd0, head.item.data_byte}, 32'h0000_0040,
                       32'h0000_007F, cfg.polynomial);
      crcc_pkg::WM_8:
        folded = fold8(base ^ {24'd0, head.item.data_byte}, 32'h0000_0080,
                       32'h0000_00FF, cfg.polynomial);
      crcc_pkg::WM_16:
        folded = fold8(base ^ {16'd0, head.item.data_byte, 8'd0}, 32'h0000_8000,
                       32'h0000_FFFF, cfg.polynomial);
      crcc_pkg::WM_32:
        folded = fold8(base ^ {head.item.data_byte, 24'd0}, 32'h8000_0000,
                       32'hFFFF_FFFF, cfg.polynomial);
      default:
        folded = base;
    endcase
  end

  // Output reflection over 8 or 16 bits; 32-bit results are not reflected
  always_comb begin
    result = folded;
    if (cfg.reflect_output) begin
      if (cfg.width_mode <= 8'd8) begin
        result = {24'd0, crcc_pkg::rev8(folded[7:0])};
      end else if (cfg.width_mode <= 8'd16) begin
        result = {16'd0, crcc_pkg::rev16(folded[15:0])};
      end
    end
  end

  // A last byte needs a free output slot; other bytes pop freely
  assign out_free = !oval_r || out_ready;
  assign pop      = head.valid && (!head.item.last_byte || out_free);

  always_comb begin
    crc_nxt   = crc_r;
    start_nxt = start_r;
    oval_nxt  = oval_r;
    odata_nxt = odata_r;
    if (oval_r && out_ready) begin
      oval_nxt = 1'b0;
    end
    if (pop) begin
      crc_nxt   = folded;
      start_nxt = head.item.last_byte;
      if (head.item.last_byte) begin
        oval_nxt  = 1'b1;
        odata_nxt = result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= '0;
      start_r <= 1'b1;
      oval_r  <= 1'b0;
    end else begin
      crc_r   <= crc_nxt;
      start_r <= start_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
  end

  assign out_valid     = oval_r;
  assign out_data      = odata_r;
  assign stat.pop      = pop;
  assign stat.pop_last = pop && head.item.last_byte;

endmodule
